// ===== src/ssp_pkg.sv =====
// Shared widths, register indexes and constants of the smoothstep patch interpolator.
package ssp_pkg;

	localparam int HEIGHT_W    = 16;
	localparam int SPAN_W      = 9;
	localparam int FRAC_W      = 16;
	localparam int WEIGHT_W    = FRAC_W + 1;
	localparam int S_TDATA_W   = 24;
	localparam int M_TDATA_W   = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = FRAC_W / DIV_BITS;
	localparam int WEIGHT_LAT = DIV_STAGES + 2;
	localparam int PIPE_DEPTH = WEIGHT_LAT + 2;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
	localparam logic [WEIGHT_W:0]   SMOOTH_K   = 18'd196608;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CORNER_TL = 3'd0,
		REG_CORNER_TR = 3'd1,
		REG_CORNER_BL = 3'd2,
		REG_CORNER_BR = 3'd3,
		REG_SPAN_COLS = 3'd4,
		REG_SPAN_ROWS = 3'd5
	} cfg_index_t;

endpackage

// ===== src/ssp_weight.sv =====
// Pipelined fraction divider and smoothstep weight for one axis.
module ssp_weight (
	input  logic                            clk,
	input  logic [ssp_pkg::WEIGHT_LAT-1:0]  adv,
	input  logic [ssp_pkg::SPAN_W-1:0]      offset,
	input  logic [ssp_pkg::SPAN_W-1:0]      span,
	output logic [ssp_pkg::WEIGHT_W-1:0]    weight
);
	import ssp_pkg::*;

	typedef struct packed {
		logic [SPAN_W-1:0] rem;
		logic [FRAC_W-1:0] quo;
	} div_t;

	function automatic div_t div_steps(div_t d, logic [SPAN_W-1:0] s);
		div_t r;
		logic [SPAN_W:0] t;
		r = d;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r.rem, 1'b0};
			if (t >= {1'b0, s}) begin
				t = t - {1'b0, s};
				r.quo = {r.quo[FRAC_W-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[FRAC_W-2:0], 1'b0};
			end
			r.rem = t[SPAN_W-1:0];
		end
		return r;
	endfunction

	div_t                    div_s  [DIV_STAGES];
	logic                    full_s [DIV_STAGES];
	logic [WEIGHT_W-1:0]     frac;
	logic [2*WEIGHT_W-1:0]   p2_s5;
	logic [WEIGHT_W:0]       t_s5;
	logic [3*WEIGHT_W:0]     prod;
	logic [WEIGHT_W-1:0]     weight_s6;

	// clamp: an offset at or beyond the span gives a fraction of exactly one
	assign frac = full_s[DIV_STAGES-1] ? WEIGHT_ONE : {1'b0, div_s[DIV_STAGES-1].quo};
	assign prod = p2_s5 * t_s5;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			full_s[0] <= offset >= span;
			div_s[0]  <= div_steps('{rem: offset, quo: '0}, span);
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (adv[k]) begin
				full_s[k] <= full_s[k-1];
				div_s[k]  <= div_steps(div_s[k-1], span);
			end
		end
		if (adv[DIV_STAGES]) begin
			p2_s5 <= frac * frac;
			t_s5  <= SMOOTH_K - {frac, 1'b0};
		end
		if (adv[DIV_STAGES+1]) begin
			weight_s6 <= prod[3*FRAC_W:2*FRAC_W];
		end
	end

	assign weight = weight_s6;

endmodule

// ===== src/smoothstep_patch_interpolator_unit.sv =====
// Top level of the smoothstep patch interpolator: configuration, pipeline control and blends.
//
// Takes one point word per cycle while s_tready is high and returns one height word per
// point, in order. The pipeline consists of the fraction divider, which resolves four
// quotient bits in each of four stages, followed by two stages for the smoothstep products
// and two for the edge and vertical blends. Every stage holds its own valid bit, so bubbles
// close up under backpressure and s_tready stays high while any stage is empty. Corner
// heights and spans are to be written through the cfg port only while no point is in
// flight; the block itself does not enforce this. A span of zero acts as one and a span
// above SPAN_MAX as SPAN_MAX, which is capped at 511. s_tdata: column_offset [8:0],
// row_offset [17:9], zero fill [23:18]. m_tdata: point_height [15:0], signed Q8.8.
module smoothstep_patch_interpolator_unit #(
	parameter int SPAN_MAX = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ssp_pkg::S_TDATA_W-1:0]     s_tdata,   // column_offset, row_offset
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ssp_pkg::M_TDATA_W-1:0]     m_tdata,   // point_height
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ssp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ssp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ssp_pkg::*;

	localparam int SPAN_LIMIT = (1 << SPAN_W) - 1;
	localparam int SPAN_CAP   = (SPAN_MAX > SPAN_LIMIT) ? SPAN_LIMIT : SPAN_MAX;

	function automatic logic [SPAN_W-1:0] eff_span(logic [SPAN_W-1:0] s);
		logic [SPAN_W-1:0] r;
		if (s == '0) begin
			r = SPAN_W'(1);
		end else if (s > SPAN_W'(SPAN_CAP)) begin
			r = SPAN_W'(SPAN_CAP);
		end else begin
			r = s;
		end
		return r;
	endfunction

	function automatic logic signed [HEIGHT_W-1:0] blend(
		logic signed [HEIGHT_W-1:0] a,
		logic signed [HEIGHT_W-1:0] b,
		logic [WEIGHT_W-1:0]        w
	);
		logic signed [HEIGHT_W:0]          d;
		logic signed [2*WEIGHT_W:0]        p;
		logic signed [HEIGHT_W+2:0]        q;
		logic signed [HEIGHT_W+2:0]        sum;
		logic signed [HEIGHT_W-1:0]        r;
		d   = (HEIGHT_W+1)'(b) - (HEIGHT_W+1)'(a);
		p   = (2*WEIGHT_W+1)'(d) * (2*WEIGHT_W+1)'($signed({1'b0, w}));
		q   = p[2*WEIGHT_W:FRAC_W];
		sum = (HEIGHT_W+3)'(a) + q;
		if (sum > (HEIGHT_W+3)'(32767)) begin
			r = 16'sh7fff;
		end else if (sum < -(HEIGHT_W+3)'(32768)) begin
			r = 16'sh8000;
		end else begin
			r = sum[HEIGHT_W-1:0];
		end
		return r;
	endfunction

	logic signed [HEIGHT_W-1:0] corner_tl_q, corner_tr_q, corner_bl_q, corner_br_q;
	logic [SPAN_W-1:0]          span_cols_q, span_rows_q;
	logic [PIPE_DEPTH:1]        valid_q;
	logic [PIPE_DEPTH:1]        valid_in;
	logic [PIPE_DEPTH:1]        en;
	logic [WEIGHT_W-1:0]        wx, wy, wy_s7;
	logic signed [HEIGHT_W-1:0] top_s7, bot_s7, height_s8;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_tl_q <= '0;
			corner_tr_q <= '0;
			corner_bl_q <= '0;
			corner_br_q <= '0;
			span_cols_q <= SPAN_W'(1);
			span_rows_q <= SPAN_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CORNER_TL: corner_tl_q <= cfg_data;
				REG_CORNER_TR: corner_tr_q <= cfg_data;
				REG_CORNER_BL: corner_bl_q <= cfg_data;
				REG_CORNER_BR: corner_br_q <= cfg_data;
				REG_SPAN_COLS: span_cols_q <= eff_span(cfg_data[SPAN_W-1:0]);
				REG_SPAN_ROWS: span_rows_q <= eff_span(cfg_data[SPAN_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// advance a stage when it is empty or the next one advances; the last stage also when m_tready is high
	always_comb begin
		en[PIPE_DEPTH] = !valid_q[PIPE_DEPTH] || m_tready;
		for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	assign valid_in = {valid_q[PIPE_DEPTH-1:1], s_tvalid};
	assign s_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 1; k <= PIPE_DEPTH; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_in[k];
				end
			end
		end
	end

	ssp_weight u_weight_x (
		.clk    (clk),
		.adv    (en[WEIGHT_LAT:1]),
		.offset (s_tdata[SPAN_W-1:0]),
		.span   (span_cols_q),
		.weight (wx)
	);

	ssp_weight u_weight_y (
		.clk    (clk),
		.adv    (en[WEIGHT_LAT:1]),
		.offset (s_tdata[2*SPAN_W-1:SPAN_W]),
		.span   (span_rows_q),
		.weight (wy)
	);

	always_ff @(posedge clk) begin
		if (en[PIPE_DEPTH-1]) begin
			top_s7 <= blend(corner_tl_q, corner_tr_q, wx);
			bot_s7 <= blend(corner_bl_q, corner_br_q, wx);
			wy_s7  <= wy;
		end
		if (en[PIPE_DEPTH]) begin
			height_s8 <= blend(top_s7, bot_s7, wy_s7);
		end
	end

	assign m_tvalid = valid_q[PIPE_DEPTH];
	assign m_tdata  = height_s8;

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q[PIPE_DEPTH] |-> s_tready)
		else $error("input held off with an empty output stage");

	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(&valid_q) && !m_tready |-> !s_tready)
		else $error("word accepted into a full stalled pipeline");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[WEIGHT_LAT] |-> (wx <= WEIGHT_ONE) && (wy <= WEIGHT_ONE))
		else $error("smoothstep weight above one");

	a_top_between_corners: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[PIPE_DEPTH-1] |->
			((top_s7 >= corner_tl_q) && (top_s7 <= corner_tr_q)) ||
			((top_s7 <= corner_tl_q) && (top_s7 >= corner_tr_q)))
		else $error("top edge blend outside its corners");

endmodule
